/* rtl/bmhq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared codes and default sizes for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int DefHeapSlots   = 256;
    localparam int DefPayloadBits = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

/* rtl/binary_min_heap_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// One-based binary min-heap of (signed priority, payload) words held in a
// synchronous memory. Requests: insert, remove minimum, peek minimum.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// word follows, valid for the single cycle o_valid is high, and it cannot be
// stalled. A rejected insert, an empty remove or peek and the unused opcode
// are answered straight from idle; peek reads the root and then answers;
// insert climbs the new word one level per step; remove reads the root and
// the last word, then sinks the moved word one level per step. A heap of
// HEAP_SLOTS slots has at most log2(HEAP_SLOTS) levels. The rate is set by
// the heap walk, one level per cycle through the memory's registered read
// ports. At most HEAP_SLOTS-1 words are held.
// ----------------------------------------------------------------------------
module binary_min_heap_queue #(
    parameter int HEAP_SLOTS   = bmhq_pkg::DefHeapSlots,
    parameter int PAYLOAD_BITS = bmhq_pkg::DefPayloadBits
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_in_priority,
    input  logic [31:0]        i_in_payload,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_out_priority,
    output logic [31:0]        o_out_payload,
    output logic [7:0]         o_entry_count
);
    import bmhq_pkg::*;

    localparam int IW = $clog2(HEAP_SLOTS);
    localparam int EW = 32 + PAYLOAD_BITS;
    localparam logic [IW-1:0] MaxFill  = IW'(HEAP_SLOTS - 1);
    localparam logic [IW:0]   SlotsExt = (IW + 1)'(HEAP_SLOTS);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_PEEK    = 3'd1;
    localparam logic [2:0] S_INS     = 3'd2;
    localparam logic [2:0] S_REM_TOP = 3'd3;
    localparam logic [2:0] S_REM_CMP = 3'd4;

    logic [EW-1:0] heap_mem [HEAP_SLOTS];

    logic [2:0]         r_state, n_state;
    logic [IW-1:0]      r_fill, n_fill;
    logic [IW-1:0]      r_n, n_n;
    logic [IW-1:0]      r_last, n_last;
    logic [EW-1:0]      r_entry, n_entry;
    logic [EW-1:0]      r_moved, n_moved;
    logic [EW-1:0]      r_top, n_top;
    logic [EW-1:0]      r_rda, r_rdb;
    logic               r_valid, n_valid;
    logic [1:0]         r_status, n_status;
    logic signed [31:0] r_oprio, n_oprio;
    logic [31:0]        r_opay, n_opay;

    logic [IW-1:0] w_ra, w_rb, w_wa;
    logic          w_we;
    logic [EW-1:0] w_wd;
    logic [IW-1:0] w_fill_inc;
    logic [IW:0]   w_m, w_m1, w_last_ext, w_cidx;
    logic          w_right;
    logic [EW-1:0] w_child;
    logic [31:0]   w_cnt;

    function automatic logic signed [31:0] prio_of(input logic [EW-1:0] e);
        return $signed(e[EW-1 -: 32]);
    endfunction

    function automatic logic [IW-1:0] clamp_addr(input logic [IW:0] a);
        return (a < SlotsExt) ? a[IW-1:0] : '0;
    endfunction

    assign w_fill_inc = r_fill + 1'b1;
    assign w_m        = {r_n, 1'b0};
    assign w_m1       = {r_n, 1'b1};
    assign w_last_ext = {1'b0, r_last};
    assign w_right    = (w_m1 < w_last_ext) && (prio_of(r_rda) > prio_of(r_rdb));
    assign w_child    = w_right ? r_rdb : r_rda;
    assign w_cidx     = w_right ? w_m1 : w_m;

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_n      = r_n;
        n_last   = r_last;
        n_entry  = r_entry;
        n_moved  = r_moved;
        n_top    = r_top;
        n_valid  = 1'b0;
        n_status = ST_OK;
        n_oprio  = '0;
        n_opay   = '0;
        w_ra     = '0;
        w_rb     = '0;
        w_we     = 1'b0;
        w_wa     = r_n;
        w_wd     = r_entry;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_opcode)
                        OP_INSERT: begin
                            if (r_fill == MaxFill) begin
                                n_valid  = 1'b1;
                                n_status = ST_FULL;
                            end else begin
                                n_fill  = w_fill_inc;
                                n_n     = w_fill_inc;
                                n_entry = {i_in_priority, i_in_payload[PAYLOAD_BITS-1:0]};
                                w_ra    = w_fill_inc >> 1;
                                n_state = S_INS;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_fill == '0) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                w_ra    = IW'(1);
                                w_rb    = r_fill;
                                n_last  = r_fill;
                                n_n     = IW'(1);
                                n_fill  = r_fill - 1'b1;
                                n_state = S_REM_TOP;
                            end
                        end
                        OP_PEEK: begin
                            if (r_fill == '0) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                w_ra    = IW'(1);
                                n_state = S_PEEK;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_PEEK: begin
                n_valid = 1'b1;
                n_oprio = prio_of(r_rda);
                n_opay  = 32'(r_rda[PAYLOAD_BITS-1:0]);
                n_state = S_IDLE;
            end
            S_INS: begin
                w_we = 1'b1;
                if (r_n != IW'(1) && prio_of(r_entry) < prio_of(r_rda)) begin
                    w_wd = r_rda;
                    n_n  = r_n >> 1;
                    w_ra = r_n >> 2;
                end else begin
                    w_wd    = r_entry;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_REM_TOP: begin
                n_top   = r_rda;
                n_moved = r_rdb;
                w_ra    = clamp_addr((IW + 1)'(2));
                w_rb    = clamp_addr((IW + 1)'(3));
                n_state = S_REM_CMP;
            end
            S_REM_CMP: begin
                w_we = 1'b1;
                if (w_m < w_last_ext && prio_of(r_moved) > prio_of(w_child)) begin
                    w_wd = w_child;
                    n_n  = w_cidx[IW-1:0];
                    w_ra = clamp_addr({w_cidx[IW-1:0], 1'b0});
                    w_rb = clamp_addr({w_cidx[IW-1:0], 1'b1});
                end else begin
                    w_wd    = r_moved;
                    n_valid = 1'b1;
                    n_oprio = prio_of(r_top);
                    n_opay  = 32'(r_top[PAYLOAD_BITS-1:0]);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            heap_mem[w_wa] <= w_wd;
        end
        r_rda <= heap_mem[w_ra];
        r_rdb <= heap_mem[w_rb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_last   <= n_last;
        r_entry  <= n_entry;
        r_moved  <= n_moved;
        r_top    <= n_top;
        r_status <= n_status;
        r_oprio  <= n_oprio;
        r_opay   <= n_opay;
    end

    assign w_cnt          = 32'(r_fill);
    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_out_priority = r_oprio;
    assign o_out_payload  = r_opay;
    assign o_entry_count  = w_cnt[7:0];

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= MaxFill)
        else $error("fill count beyond heap capacity");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted request neither in progress nor answered");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (r_fill == MaxFill))
        else $error("full status with spare capacity");

    a_sift_down_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REM_CMP) |-> (r_n <= r_last && r_fill == r_last - 1'b1))
        else $error("sift-down index beyond last entry");

    a_no_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy || start))
        else $error("result without a request");
`endif

endmodule
